// File: sv/tlr_pkg.sv
// shared types and constants for the terminated line receiver
// no dependencies; imported by every module of the block
package tlr_pkg;

    // fixed field widths
    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 7;
    localparam int DATA_W     = 32;
    localparam int PADDR_W    = 3;
    localparam int DEF_DEPTH  = 64;
    localparam int MIN_SIZE   = 2;
    localparam int SIZE_RESET = 64;

    // register index
    localparam logic REG_LINE_SIZE = 1'b0;

    // result kinds
    localparam logic KIND_LINE  = 1'b0;
    localparam logic KIND_ERROR = 1'b1;

    // line terminator
    localparam logic [BYTE_W-1:0] TERM_BYTE = 8'h00;

    // control sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TERM,
        ST_ERR,
        ST_RD,
        ST_SEND
    } state_t;

    // configuration seen by the control path
    typedef struct packed {
        logic             clr;
        logic [LEN_W-1:0] size;
    } cfg_t;

endpackage

// File: sv/tlr_cfg.sv
// apb register file holding the line size register
// depends on tlr_pkg
module tlr_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tlr_pkg::PADDR_W-1:0]   paddr,
    input  logic [tlr_pkg::DATA_W-1:0]    pwdata,
    output logic [tlr_pkg::DATA_W-1:0]    prdata,
    output tlr_pkg::cfg_t                 cfg
);
    import tlr_pkg::*;

    logic [LEN_W-1:0] size_reg;
    logic             wr_hit;

    // write strobe for the size register
    assign wr_hit = psel && penable && pwrite && (paddr[PADDR_W-1] == REG_LINE_SIZE);

    // size register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= LEN_W'(SIZE_RESET);
        end
        else if (wr_hit)
        begin
            size_reg <= pwdata[LEN_W-1:0];
        end
    end

    // read back
    always_comb
    begin
        prdata = '0;
        if (paddr[PADDR_W-1] == REG_LINE_SIZE)
        begin
            prdata = {{(DATA_W-LEN_W){1'b0}}, size_reg};
        end
    end

    assign cfg.clr  = wr_hit;
    assign cfg.size = size_reg;

endmodule

// File: sv/tlr_mem.sv
// ping-pong line memory: both banks in one array, bank select is the top address bit
// depends on tlr_pkg; one write port, one registered read port
module tlr_mem #(
    parameter int BUF_DEPTH = tlr_pkg::DEF_DEPTH,
    parameter int ADDR_W    = $clog2(BUF_DEPTH) + 1
) (
    input  logic                        clk,
    input  logic                        we,
    input  logic [ADDR_W-1:0]           waddr,
    input  logic [tlr_pkg::BYTE_W-1:0]  wdata,
    input  logic                        re,
    input  logic [ADDR_W-1:0]           raddr,
    output logic [tlr_pkg::BYTE_W-1:0]  rdata
);
    import tlr_pkg::*;

    localparam int DEPTH = 2 ** ADDR_W;

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/tlr_ctrl.sv
// control sequencer: stores bytes, appends the terminator, swaps banks, streams finished
// lines out of the memory and reports receive errors; depends on tlr_pkg
module tlr_ctrl #(
    parameter int BUF_DEPTH = tlr_pkg::DEF_DEPTH,
    parameter int IDX_W     = $clog2(BUF_DEPTH)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  tlr_pkg::cfg_t               cfg,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [tlr_pkg::BYTE_W-1:0]  rx_byte,
    input  logic                        byte_ready,
    input  logic                        overrun,
    input  logic                        framing_error,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        result_kind,
    output logic [tlr_pkg::BYTE_W-1:0]  line_byte,
    output logic [tlr_pkg::LEN_W-1:0]   line_length,
    output logic                        last_of_run,
    output logic                        mem_we,
    output logic [IDX_W:0]              mem_waddr,
    output logic [tlr_pkg::BYTE_W-1:0]  mem_wdata,
    output logic                        mem_re,
    output logic [IDX_W:0]              mem_raddr,
    input  logic [tlr_pkg::BYTE_W-1:0]  mem_rdata
);
    import tlr_pkg::*;

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  cnt_reg, cnt_next;
    logic              bank_reg, bank_next;
    logic              emit_bank_reg, emit_bank_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;

    logic              out_valid_reg;
    logic              kind_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic [LEN_W-1:0]  length_reg;
    logic              last_reg;

    logic [LEN_W-1:0]  eff_size;
    logic [LEN_W-1:0]  new_len;
    logic              accept;
    logic              is_err;
    logic              add_term;
    logic              finish;
    logic              out_free;
    logic              is_last;
    logic              load_err;
    logic              load_line;

    // effective size clamped to the supported range
    always_comb
    begin
        eff_size = cfg.size;
        if (cfg.size < LEN_W'(MIN_SIZE))
        begin
            eff_size = LEN_W'(MIN_SIZE);
        end
        else if (cfg.size > LEN_W'(BUF_DEPTH))
        begin
            eff_size = LEN_W'(BUF_DEPTH);
        end
    end

    // decode of the incoming beat
    assign accept   = in_valid && (state_reg == ST_IDLE);
    assign is_err   = !byte_ready || overrun || framing_error;
    assign new_len  = {{(LEN_W-IDX_W){1'b0}}, cnt_reg} + LEN_W'(1);
    assign add_term = (new_len + LEN_W'(1)) == eff_size;
    assign finish   = add_term || (rx_byte == TERM_BYTE);
    assign out_free = !out_valid_reg || !out_stall;
    assign is_last  = ({{(LEN_W-IDX_W){1'b0}}, idx_reg} + LEN_W'(1)) == len_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (is_err)
                    begin
                        state_next = out_free ? ST_IDLE : ST_ERR;
                    end
                    else if (add_term)
                    begin
                        state_next = ST_TERM;
                    end
                    else if (finish)
                    begin
                        state_next = ST_RD;
                    end
                end
            end
            ST_TERM:
            begin
                state_next = ST_RD;
            end
            ST_ERR:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_RD:
            begin
                state_next = ST_SEND;
            end
            ST_SEND:
            begin
                if (out_free)
                begin
                    state_next = is_last ? ST_IDLE : ST_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs and datapath updates
    always_comb
    begin
        in_stall       = 1'b1;
        mem_we         = 1'b0;
        mem_waddr      = {bank_reg, cnt_reg};
        mem_wdata      = rx_byte;
        mem_re         = 1'b0;
        mem_raddr      = {emit_bank_reg, idx_reg};
        load_err       = 1'b0;
        load_line      = 1'b0;
        cnt_next       = cnt_reg;
        bank_next      = bank_reg;
        emit_bank_next = emit_bank_reg;
        len_next       = len_reg;
        idx_next       = idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (cfg.clr)
                begin
                    cnt_next = '0;
                end
                if (accept)
                begin
                    if (is_err)
                    begin
                        load_err = out_free;
                    end
                    else
                    begin
                        mem_we = 1'b1;
                        if (finish)
                        begin
                            emit_bank_next = bank_reg;
                            bank_next      = !bank_reg;
                            idx_next       = '0;
                            len_next       = add_term ? (new_len + LEN_W'(1)) : new_len;
                            cnt_next       = add_term ? new_len[IDX_W-1:0] : '0;
                        end
                        else
                        begin
                            cnt_next = new_len[IDX_W-1:0];
                        end
                    end
                end
            end
            ST_TERM:
            begin
                // terminator goes after the last data byte of the finished bank
                mem_we    = 1'b1;
                mem_waddr = {emit_bank_reg, cnt_reg};
                mem_wdata = TERM_BYTE;
                cnt_next  = '0;
            end
            ST_ERR:
            begin
                load_err = out_free;
            end
            ST_RD:
            begin
                mem_re = 1'b1;
            end
            ST_SEND:
            begin
                if (out_free)
                begin
                    load_line = 1'b1;
                    if (!is_last)
                    begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            bank_reg      <= 1'b0;
            emit_bank_reg <= 1'b0;
            len_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            bank_reg      <= bank_next;
            emit_bank_reg <= emit_bank_next;
            len_reg       <= len_next;
            idx_reg       <= idx_next;
            if (load_err || load_line)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // output beat register
    always_ff @(posedge clk)
    begin
        if (load_err)
        begin
            kind_reg   <= KIND_ERROR;
            byte_reg   <= '0;
            length_reg <= '0;
            last_reg   <= 1'b1;
        end
        else if (load_line)
        begin
            kind_reg   <= KIND_LINE;
            byte_reg   <= mem_rdata;
            length_reg <= len_reg;
            last_reg   <= is_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_kind = kind_reg;
    assign line_byte   = byte_reg;
    assign line_length = length_reg;
    assign last_of_run = last_reg;

endmodule

// File: sv/terminated_line_receiver_pingpong_unit.sv
// timing: an error beat enters the output register at the accepting edge if the output is
// free, else from ST_ERR; a finished line passes ST_TERM (if a terminator is added), ST_RD
// and ST_SEND, each byte read by the single registered read port in ST_RD and loaded in
// ST_SEND when the output is free; a byte that does not end a line leaves the unit idle
// reset: control state and line size (64) reset asynchronously; bank contents are not cleared
module terminated_line_receiver_pingpong_unit #(
    parameter int BUF_DEPTH = tlr_pkg::DEF_DEPTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tlr_pkg::PADDR_W-1:0]   paddr,
    input  logic [tlr_pkg::DATA_W-1:0]    pwdata,
    output logic [tlr_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [tlr_pkg::BYTE_W-1:0]    rx_byte,
    input  logic                          byte_ready,
    input  logic                          overrun,
    input  logic                          framing_error,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          result_kind,
    output logic [tlr_pkg::BYTE_W-1:0]    line_byte,
    output logic [tlr_pkg::LEN_W-1:0]     line_length,
    output logic                          last_of_run
);
    import tlr_pkg::*;

    localparam int IDX_W = $clog2(BUF_DEPTH);

    cfg_t              cfg;
    logic              mem_we;
    logic [IDX_W:0]    mem_waddr;
    logic [BYTE_W-1:0] mem_wdata;
    logic              mem_re;
    logic [IDX_W:0]    mem_raddr;
    logic [BYTE_W-1:0] mem_rdata;

    assign pready = 1'b1;

    // register file
    tlr_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // line sequencer
    tlr_ctrl #(
        .BUF_DEPTH (BUF_DEPTH),
        .IDX_W     (IDX_W)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .rx_byte       (rx_byte),
        .byte_ready    (byte_ready),
        .overrun       (overrun),
        .framing_error (framing_error),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .result_kind   (result_kind),
        .line_byte     (line_byte),
        .line_length   (line_length),
        .last_of_run   (last_of_run),
        .mem_we        (mem_we),
        .mem_waddr     (mem_waddr),
        .mem_wdata     (mem_wdata),
        .mem_re        (mem_re),
        .mem_raddr     (mem_raddr),
        .mem_rdata     (mem_rdata)
    );

    // ping-pong bank memory
    tlr_mem #(
        .BUF_DEPTH (BUF_DEPTH),
        .ADDR_W    (IDX_W + 1)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule
